// ----- rtl/ptmq_pkg.sv -----
`timescale 1ns / 1ps

package ptmq_pkg;

   localparam int ID_W     = 32;
   localparam int KIND_W   = 2;
   localparam int STAT_W   = 2;
   localparam int BSLOT_W  = 4;
   localparam int MSG_W    = 3 * ID_W;
   // bind_slot is 4 bits wide, so only the first 16 slots can be bound
   localparam int BIND_REACH = 16;

   typedef enum logic [KIND_W-1:0] {
      KIND_SEND = 2'd0,
      KIND_RECV = 2'd1,
      KIND_BIND = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_BIND,
      S_MATCH,
      S_LOOKUP,
      S_ACCESS,
      S_READ,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [ID_W-1:0]    dest_tid;
      logic [ID_W-1:0]    src_tid;
      logic [ID_W-1:0]    msg_code;
      logic [ID_W-1:0]    payload;
      logic [BSLOT_W-1:0] bind_slot;
      logic [ID_W-1:0]    bind_id;
      logic               bind_active;
   } req_item_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [ID_W-1:0]   out_src_tid;
      logic [ID_W-1:0]   out_msg_code;
      logic [ID_W-1:0]   out_payload;
   } rsp_item_type;

   typedef struct packed {
      logic capture;
      logic wr_slot;
      logic match;
      logic lookup;
      logic access;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic recv_ok;
   } dp_status_type;

endpackage

// ----- rtl/ptmq_if.sv -----
`timescale 1ns / 1ps

interface ptmq_req_if import ptmq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [ID_W-1:0]    dest_tid;
   logic [ID_W-1:0]    src_tid;
   logic [ID_W-1:0]    msg_code;
   logic [ID_W-1:0]    payload;
   logic [BSLOT_W-1:0] bind_slot;
   logic [ID_W-1:0]    bind_id;
   logic               bind_active;

   modport source (
      output valid, kind, dest_tid, src_tid, msg_code, payload,
             bind_slot, bind_id, bind_active,
      input  ready
   );
   modport sink (
      input  valid, kind, dest_tid, src_tid, msg_code, payload,
             bind_slot, bind_id, bind_active,
      output ready
   );
endinterface

interface ptmq_rsp_if import ptmq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [ID_W-1:0]   out_src_tid;
   logic [ID_W-1:0]   out_msg_code;
   logic [ID_W-1:0]   out_payload;

   modport source (
      output valid, status, out_src_tid, out_msg_code, out_payload,
      input  ready
   );
   modport sink (
      input  valid, status, out_src_tid, out_msg_code, out_payload,
      output ready
   );
endinterface

// ----- rtl/ptmq_ctrl.sv -----
`timescale 1ns / 1ps

module ptmq_ctrl import ptmq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  kind_type      req_kind,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type stat,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  KIND_SEND, KIND_RECV: state_in = S_MATCH;
                  KIND_BIND:            state_in = S_BIND;
                  default:              state_in = S_RESP;
               endcase
            end
         end
         S_BIND:   state_in = S_RESP;
         S_MATCH:  state_in = S_LOOKUP;
         S_LOOKUP: state_in = S_ACCESS;
         S_ACCESS: state_in = stat.recv_ok ? S_READ : S_RESP;
         S_READ:   state_in = S_RESP;
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_BIND:   cmd.wr_slot = 1'b1;
         S_MATCH:  cmd.match  = 1'b1;
         S_LOOKUP: cmd.lookup = 1'b1;
         S_ACCESS: cmd.access = 1'b1;
         S_READ:   ;
         S_RESP:   cmd.load_rsp = !rsp_valid_ff || rsp_ready;
         default:  ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready)        rsp_valid_in = 1'b0;
      else                       rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/ptmq_dpath.sv -----
`timescale 1ns / 1ps

module ptmq_dpath import ptmq_pkg::*; #(
   parameter int SLOTS       = 16,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type stat,
   input  req_item_type  req_item,
   output rsp_item_type  rsp_item
);

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int MD = SLOTS * QUEUE_DEPTH;
   localparam int AW = (MD > 1) ? $clog2(MD) : 1;

   function automatic logic [PW-1:0] nxt_ptr(input logic [PW-1:0] p);
      return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   req_item_type item_ff;

   // thread table
   logic [ID_W-1:0]  slot_id_ff [SLOTS];
   logic [SLOTS-1:0] slot_use_ff;
   logic [SLOTS-1:0] match_ff;

   // per-slot queue pointers; a slot whose valid bit is clear reads as all-zero pointers
   logic [PW-1:0]    head_mem [SLOTS];
   logic [PW-1:0]    tail_mem [SLOTS];
   logic [CW-1:0]    cnt_mem  [SLOTS];
   logic [SLOTS-1:0] ptr_vld_ff;
   logic [PW-1:0]    head_rd_ff, tail_rd_ff;
   logic [CW-1:0]    cnt_rd_ff;
   logic             vld_rd_ff;

   logic [MSG_W-1:0] msg_mem [MD];
   logic [MSG_W-1:0] msg_rd_ff;

   logic [SW-1:0]    slot_ff, enc_slot;
   logic             found_ff, enc_found;
   logic [STAT_W-1:0] status_ff;
   logic             recv_ok_ff;
   rsp_item_type     rsp_ff;

   logic [PW-1:0]    cur_head, cur_tail, nxt_head, nxt_tail;
   logic [CW-1:0]    cur_cnt, nxt_cnt;
   logic             is_send, q_full, q_empty, send_ok, recv_ok, ptr_we, msg_we;
   status_type       acc_status;
   logic [AW-1:0]    msg_addr;

   always_ff @(posedge clock) begin
      if (cmd.capture) item_ff <= req_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) slot_id_ff[s] <= '0;
         slot_use_ff <= '0;
      end else if (cmd.wr_slot) begin
         for (int s = 0; s < SLOTS; s++) begin
            if (s < BIND_REACH && item_ff.bind_slot == BSLOT_W'(s)) begin
               slot_id_ff[s]  <= item_ff.bind_id;
               slot_use_ff[s] <= item_ff.bind_active;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.match) begin
         for (int s = 0; s < SLOTS; s++)
            match_ff[s] <= slot_use_ff[s] && (slot_id_ff[s] == item_ff.dest_tid);
      end
   end

   // lowest matching slot wins
   always_comb begin
      enc_found = 1'b0;
      enc_slot  = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (match_ff[s]) begin
            enc_found = 1'b1;
            enc_slot  = SW'(s);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         slot_ff    <= enc_slot;
         found_ff   <= enc_found;
         head_rd_ff <= head_mem[enc_slot];
         tail_rd_ff <= tail_mem[enc_slot];
         cnt_rd_ff  <= cnt_mem[enc_slot];
         vld_rd_ff  <= ptr_vld_ff[enc_slot];
      end
   end

   always_comb begin
      cur_head = vld_rd_ff ? head_rd_ff : '0;
      cur_tail = vld_rd_ff ? tail_rd_ff : '0;
      cur_cnt  = vld_rd_ff ? cnt_rd_ff  : '0;
      is_send  = (kind_type'(item_ff.kind) == KIND_SEND);
      q_full   = (cur_cnt == CW'(QUEUE_DEPTH));
      q_empty  = (cur_cnt == '0);
      send_ok  = found_ff && is_send && !q_full;
      recv_ok  = found_ff && !is_send && !q_empty;
      priority if (!found_ff) acc_status = STAT_NOT_FOUND;
      else if (is_send)       acc_status = q_full ? STAT_FULL : STAT_OK;
      else                    acc_status = q_empty ? STAT_EMPTY : STAT_OK;
      nxt_head = recv_ok ? nxt_ptr(cur_head) : cur_head;
      nxt_tail = send_ok ? nxt_ptr(cur_tail) : cur_tail;
      priority if (send_ok) nxt_cnt = cur_cnt + 1'b1;
      else if (recv_ok)     nxt_cnt = cur_cnt - 1'b1;
      else                  nxt_cnt = cur_cnt;
      ptr_we   = cmd.access && (send_ok || recv_ok);
      msg_we   = cmd.access && send_ok;
      msg_addr = AW'(int'(slot_ff) * QUEUE_DEPTH) + AW'(is_send ? cur_tail : cur_head);
   end

   always_ff @(posedge clock) begin
      if (ptr_we) begin
         head_mem[slot_ff] <= nxt_head;
         tail_mem[slot_ff] <= nxt_tail;
         cnt_mem[slot_ff]  <= nxt_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)       ptr_vld_ff          <= '0;
      else if (ptr_we) ptr_vld_ff[slot_ff] <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (msg_we) msg_mem[msg_addr] <= {item_ff.src_tid, item_ff.msg_code,
                                        item_ff.payload};
      if (cmd.access && recv_ok) msg_rd_ff <= msg_mem[msg_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff  <= STAT_OK;
         recv_ok_ff <= 1'b0;
      end else if (cmd.capture) begin
         status_ff  <= STAT_OK;
         recv_ok_ff <= 1'b0;
      end else if (cmd.access) begin
         status_ff  <= acc_status;
         recv_ok_ff <= recv_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.status       <= status_ff;
         rsp_ff.out_src_tid  <= recv_ok_ff ? msg_rd_ff[MSG_W-1 -: ID_W] : '0;
         rsp_ff.out_msg_code <= recv_ok_ff ? msg_rd_ff[2*ID_W-1 -: ID_W] : '0;
         rsp_ff.out_payload  <= recv_ok_ff ? msg_rd_ff[ID_W-1:0] : '0;
      end
   end

   assign rsp_item     = rsp_ff;
   assign stat.recv_ok = recv_ok;

`ifndef SYNTHESIS
   ap_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      ptr_we |-> (nxt_cnt <= CW'(QUEUE_DEPTH)))
      else $error("queue count written above depth");
   ap_no_write_miss: assert property (@(posedge clock) disable iff (reset)
      (cmd.access && !found_ff) |-> (!ptr_we && !msg_we))
      else $error("queue state written without a matching slot");
   ap_recv_result: assert property (@(posedge clock) disable iff (reset)
      (cmd.access && recv_ok) |=> (recv_ok_ff && status_ff == STAT_OK))
      else $error("successful receive not recorded");
`endif

endmodule

// ----- rtl/per_thread_mailbox_queues_top.sv -----
`timescale 1ns / 1ps

// Mailbox engine with SLOTS thread slots, each owning a circular queue of
// QUEUE_DEPTH messages. One item is handled at a time: for a send or a receive
// the controller steps through id match, slot select with pointer table read,
// message memory access and, for a successful receive, a state for the read
// data; a bind passes through a slot write state, and an unused kind goes
// straight to the response.
// One result beat waits in an output register; the next item is accepted
// meanwhile, and the block stalls only when a second result is ready before
// the first is taken.
module per_thread_mailbox_queues_top import ptmq_pkg::*; #(
   parameter int SLOTS       = 16,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   ptmq_req_if.sink          req_chan,
   ptmq_rsp_if.source        rsp_chan
);

   ctrl_cmd_type  cmd;
   dp_status_type stat;
   req_item_type  req_item;
   rsp_item_type  rsp_item;

   assign req_item.kind        = req_chan.kind;
   assign req_item.dest_tid    = req_chan.dest_tid;
   assign req_item.src_tid     = req_chan.src_tid;
   assign req_item.msg_code    = req_chan.msg_code;
   assign req_item.payload     = req_chan.payload;
   assign req_item.bind_slot   = req_chan.bind_slot;
   assign req_item.bind_id     = req_chan.bind_id;
   assign req_item.bind_active = req_chan.bind_active;

   ptmq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (kind_type'(req_chan.kind)),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ptmq_dpath #(
      .SLOTS       (SLOTS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_item (req_item),
      .rsp_item (rsp_item)
   );

   assign rsp_chan.status       = rsp_item.status;
   assign rsp_chan.out_src_tid  = rsp_item.out_src_tid;
   assign rsp_chan.out_msg_code = rsp_item.out_msg_code;
   assign rsp_chan.out_payload  = rsp_item.out_payload;

endmodule

// ----- dv/per_thread_mailbox_queues_top_test.sv -----
`timescale 1ns / 1ps

module per_thread_mailbox_queues_top_test;
   import ptmq_pkg::*;

   localparam int SLOTS       = 16;
   localparam int QUEUE_DEPTH = 16;
   localparam int RAND_ITEMS  = 1300;

   typedef struct packed {
      logic [ID_W-1:0] sender, mtype, body;
   } mail_type;

   // Tracks thread table and per-slot mailboxes; predicts one response per request
   class mailbox_scoreboard;
      bit [ID_W-1:0] slot_id [SLOTS];
      bit            slot_live [SLOTS];
      mail_type      mbox_q [SLOTS][$];
      rsp_item_type  expected_rsp [$];
      int            mismatches = 0;

      function int pending();
         return expected_rsp.size();
      endfunction

      function void note_request(req_item_type r);
         rsp_item_type e;
         mail_type     m;
         int           hit;
         e   = '0;
         hit = -1;
         case (kind_type'(r.kind))
            KIND_BIND: begin
               if (int'(r.bind_slot) < SLOTS) begin
                  slot_id[r.bind_slot]   = r.bind_id;
                  slot_live[r.bind_slot] = r.bind_active;
               end
            end
            KIND_SEND, KIND_RECV: begin
               // lowest live slot with a matching id wins
               for (int s = 0; s < SLOTS; s++)
                  if (hit < 0 && slot_live[s] && slot_id[s] == r.dest_tid) hit = s;
               if (hit < 0) begin
                  e.status = STAT_NOT_FOUND;
               end else if (kind_type'(r.kind) == KIND_SEND) begin
                  if (mbox_q[hit].size() >= QUEUE_DEPTH) begin
                     e.status = STAT_FULL;
                  end else begin
                     m.sender = r.src_tid;
                     m.mtype  = r.msg_code;
                     m.body   = r.payload;
                     mbox_q[hit].push_back(m);
                  end
               end else if (mbox_q[hit].size() == 0) begin
                  e.status = STAT_EMPTY;
               end else begin
                  m              = mbox_q[hit].pop_front();
                  e.out_src_tid  = m.sender;
                  e.out_msg_code = m.mtype;
                  e.out_payload  = m.body;
               end
            end
            default: ;
         endcase
         expected_rsp.push_back(e);
      endfunction

      function void check_response(rsp_item_type got);
         rsp_item_type e;
         if (expected_rsp.size() == 0) begin
            $error("response beat with nothing outstanding: status %0d", got.status);
            mismatches++;
            return;
         end
         e = expected_rsp.pop_front();
         if (got.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, got.status);
            mismatches++;
         end
         if (got.out_src_tid !== e.out_src_tid) begin
            $error("out_src_tid: expected %h, got %h", e.out_src_tid, got.out_src_tid);
            mismatches++;
         end
         if (got.out_msg_code !== e.out_msg_code) begin
            $error("out_msg_code: expected %h, got %h",
                   e.out_msg_code, got.out_msg_code);
            mismatches++;
         end
         if (got.out_payload !== e.out_payload) begin
            $error("out_payload: expected %h, got %h", e.out_payload, got.out_payload);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   ptmq_req_if req_chan ();
   ptmq_rsp_if rsp_chan ();

   per_thread_mailbox_queues_top #(
      .SLOTS       (SLOTS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   mailbox_scoreboard book;
   int                req_idle_pct    = 13;
   int                rsp_stall_pct   = 81;
   int                rsp_hold_cycles = 0;
   logic [ID_W-1:0]   id_pool [8];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2ms;
      $display("per_thread_mailbox_queues_top_test: errors");
      $finish;
   end

   // Response side: random backpressure, plus a long hold-off when the stimulus asks for one
   initial begin : rsp_side
      int held;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles != 0) begin
            held            = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_chan.ready <= 1'b0;
            repeat (held) @(posedge clock);
         end
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : watch
      req_item_type seen_req;
      rsp_item_type seen_rsp;
      if (!reset && req_chan.valid && req_chan.ready) begin
         seen_req.kind        = req_chan.kind;
         seen_req.dest_tid    = req_chan.dest_tid;
         seen_req.src_tid     = req_chan.src_tid;
         seen_req.msg_code    = req_chan.msg_code;
         seen_req.payload     = req_chan.payload;
         seen_req.bind_slot   = req_chan.bind_slot;
         seen_req.bind_id     = req_chan.bind_id;
         seen_req.bind_active = req_chan.bind_active;
         book.note_request(seen_req);
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen_rsp.status       = rsp_chan.status;
         seen_rsp.out_src_tid  = rsp_chan.out_src_tid;
         seen_rsp.out_msg_code = rsp_chan.out_msg_code;
         seen_rsp.out_payload  = rsp_chan.out_payload;
         book.check_response(seen_rsp);
      end
   end

   function automatic logic [ID_W-1:0] rand_word();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [ID_W-1:0] pick_id();
      if ($urandom_range(99) < 88) return id_pool[$urandom_range(7)];
      return $urandom;
   endfunction

   function automatic req_item_type noise_req();
      req_item_type r;
      r.kind        = KIND_W'($urandom_range(3));
      r.dest_tid    = $urandom;
      r.src_tid     = $urandom;
      r.msg_code    = $urandom;
      r.payload     = $urandom;
      r.bind_slot   = BSLOT_W'($urandom_range(15));
      r.bind_id     = $urandom;
      r.bind_active = 1'($urandom_range(1));
      return r;
   endfunction

   // Called at a rising edge; returns at the edge where the beat is taken
   task automatic offer(input req_item_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.kind        <= r.kind;
      req_chan.dest_tid    <= r.dest_tid;
      req_chan.src_tid     <= r.src_tid;
      req_chan.msg_code    <= r.msg_code;
      req_chan.payload     <= r.payload;
      req_chan.bind_slot   <= r.bind_slot;
      req_chan.bind_id     <= r.bind_id;
      req_chan.bind_active <= r.bind_active;
      req_chan.valid       <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic do_bind(input logic [BSLOT_W-1:0] slot, input logic [ID_W-1:0] id,
                          input logic active);
      req_item_type r;
      r             = noise_req();
      r.kind        = KIND_BIND;
      r.bind_slot   = slot;
      r.bind_id     = id;
      r.bind_active = active;
      offer(r);
   endtask

   task automatic do_send(input logic [ID_W-1:0] rid, input logic [ID_W-1:0] snd,
                          input logic [ID_W-1:0] typ, input logic [ID_W-1:0] pay);
      req_item_type r;
      r          = noise_req();
      r.kind     = KIND_SEND;
      r.dest_tid = rid;
      r.src_tid  = snd;
      r.msg_code = typ;
      r.payload  = pay;
      offer(r);
   endtask

   task automatic do_recv(input logic [ID_W-1:0] rid);
      req_item_type r;
      r          = noise_req();
      r.kind     = KIND_RECV;
      r.dest_tid = rid;
      offer(r);
   endtask

   // Sender goes quiet until every outstanding response has been taken
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
   endtask

   initial begin : stim
      req_item_type    r;
      logic [ID_W-1:0] id;
      int              n;
      int              count;
      int              phase;
      book                 = new();
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.kind        = '0;
      req_chan.dest_tid    = '0;
      req_chan.src_tid     = '0;
      req_chan.msg_code    = '0;
      req_chan.payload     = '0;
      req_chan.bind_slot   = '0;
      req_chan.bind_id     = '0;
      req_chan.bind_active = 1'b0;
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (int i = 2; i < 8; i++) id_pool[i] = $urandom;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, unused kind, shadowed ids, full and empty queues
      do_send('0, '1, '1, '1);
      do_recv('0);
      r      = noise_req();
      r.kind = KIND_NONE;
      offer(r);
      do_bind(4'd0, '1, 1'b1);
      do_bind(4'd15, '0, 1'b1);
      do_bind(4'd3, '1, 1'b1);
      do_recv('1);
      do_send('1, '1, '1, '1);
      do_send('1, '0, '0, '0);
      repeat (QUEUE_DEPTH - 2) do_send('1, $urandom, $urandom, $urandom);
      do_send('1, '1, '0, '1);
      do_recv('1);
      // freeing slot 0 exposes slot 3 under the same id; queue contents survive
      do_bind(4'd0, '1, 1'b0);
      do_recv('1);
      do_bind(4'd0, '0, 1'b1);
      do_recv('0);

      // random traffic in three idle/stall phases
      count = 0;
      phase = 1;
      while (count < RAND_ITEMS) begin
         if (phase == 1 && count >= RAND_ITEMS / 3) begin
            drain();
            req_idle_pct  = 81;
            rsp_stall_pct = 13;
            phase         = 2;
         end else if (phase == 2 && count >= 2 * RAND_ITEMS / 3) begin
            drain();
            req_idle_pct    = 0;
            rsp_stall_pct   = 0;
            rsp_hold_cycles = 300;
            phase           = 3;
         end
         n = $urandom_range(99);
         if (n < 4) begin
            id = pick_id();
            n  = $urandom_range(14, 20);
            repeat (n) do_send(id, rand_word(), rand_word(), rand_word());
            count += n;
         end else if (n < 7) begin
            id = pick_id();
            n  = $urandom_range(8, 20);
            repeat (n) do_recv(id);
            count += n;
         end else if (n < 17) begin
            do_bind(BSLOT_W'($urandom_range(15)), pick_id(), $urandom_range(99) < 75);
            count++;
         end else if (n < 19) begin
            r      = noise_req();
            r.kind = KIND_NONE;
            offer(r);
         end else if (n < 60) begin
            do_send(pick_id(), rand_word(), rand_word(), rand_word());
            count++;
         end else begin
            do_recv(pick_id());
            count++;
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (book.mismatches == 0 && book.pending() == 0)
         $display("per_thread_mailbox_queues_top_test: clean");
      else
         $display("per_thread_mailbox_queues_top_test: errors");
      $finish;
   end

endmodule
